>>> rtl/core/fat32rl_pkg.sv
// Shared types and constants for the FAT32 root file loader.
// No dependencies; the RTL files refer to this package by scoped names, the dv files import it.
package fat32rl_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int BIS_W        = $clog2(SECTOR_BYTES);
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [31:0] EOC_MIN  = 32'h0FFF_FFF8;
    localparam logic [31:0] FAT_MASK = 32'h0FFF_FFFF;

    localparam logic [7:0] ENTRY_END       = 8'h00;
    localparam logic [7:0] ENTRY_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME  = 8'h0F;
    localparam logic [7:0] ATTR_VOLUME     = 8'h08;
    localparam logic [7:0] ATTR_SUBDIR     = 8'h10;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // result kinds
    localparam logic [2:0] K_REQ      = 3'd0;
    localparam logic [2:0] K_BYTE     = 3'd1;
    localparam logic [2:0] K_FOUND    = 3'd2;
    localparam logic [2:0] K_NOTFOUND = 3'd3;
    localparam logic [2:0] K_ERR      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_NAME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_EXT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_CLUSTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPC          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE     = 3'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sector_lba;
        logic [7:0]  file_byte;
        logic [31:0] reported_size;
        logic        last;
    } out_t;

    // results produced by one transfer, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

endpackage

>>> rtl/core/fat32rl_engine.sv
// Front part: config registers, directory scan / FAT walk state machine.
// Each accepted transfer yields zero to two result records. Uses fat32rl_pkg.
module fat32rl_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_fire,
    input  fat32rl_pkg::in_t                     in_data,
    input  logic                                 cfg_we,
    input  logic [fat32rl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fat32rl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fat32rl_pkg::push_t                   push
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_DIR   = 5'b00010,
        PH_DRAIN = 5'b00100,
        PH_FILE  = 5'b01000,
        PH_FAT   = 5'b10000
    } phase_t;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_DATA = 2'd1;
    localparam logic [1:0] SRC_FAT  = 2'd2;

    localparam int BW = fat32rl_pkg::BIS_W;

    // configuration
    logic [63:0] name_reg;
    logic [23:0] ext_reg;
    logic [27:0] root_reg;
    logic [31:0] fat_start_reg;
    logic [31:0] data_start_reg;
    logic [7:0]  spc_reg;
    logic [31:0] max_reg;

    phase_t      phase_reg, phase_next;
    logic        owner_reg, owner_next;
    logic [31:0] cc_reg, cc_next;
    logic [7:0]  sic_reg, sic_next;
    logic [BW-1:0] bis_reg, bis_next;
    logic [7:0]  efb_reg, efb_next;
    logic [7:0]  attr_reg, attr_next;
    logic        ene_reg, ene_next;
    logic [31:0] fc_reg, fc_next;
    logic [31:0] fs_reg, fs_next;
    logic [31:0] br_reg, br_next;
    logic [31:0] fatw_reg, fatw_next;

    logic [1:0]  n;
    logic [2:0]  rk   [2];
    logic [7:0]  rb   [2];
    logic [31:0] rs   [2];
    logic [1:0]  rsrc [2];

    logic        do_goto, do_next, do_req, stop, skip, sector_end;
    logic [31:0] goto_cl, fsz, data_lba, fat_lba;
    logic [8:0]  s_inc;
    logic [4:0]  e;
    logic [7:0]  b, want;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg       <= '0;
            ext_reg        <= '0;
            root_reg       <= 28'd2;
            fat_start_reg  <= '0;
            data_start_reg <= '0;
            spc_reg        <= 8'd1;
            max_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fat32rl_pkg::REG_TARGET_NAME:  name_reg       <= cfg_data;
                fat32rl_pkg::REG_TARGET_EXT:   ext_reg        <= cfg_data[23:0];
                fat32rl_pkg::REG_ROOT_CLUSTER: root_reg       <= cfg_data[27:0];
                fat32rl_pkg::REG_FAT_START:    fat_start_reg  <= cfg_data[31:0];
                fat32rl_pkg::REG_DATA_START:   data_start_reg <= cfg_data[31:0];
                fat32rl_pkg::REG_SPC:          spc_reg        <= cfg_data[7:0];
                fat32rl_pkg::REG_MAX_SIZE:     max_reg        <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        owner_next = owner_reg;
        cc_next    = cc_reg;
        sic_next   = sic_reg;
        bis_next   = bis_reg;
        efb_next   = efb_reg;
        attr_next  = attr_reg;
        ene_next   = ene_reg;
        fc_next    = fc_reg;
        fs_next    = fs_reg;
        br_next    = br_reg;
        fatw_next  = fatw_reg;
        n          = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            rk[i]   = fat32rl_pkg::K_REQ;
            rb[i]   = '0;
            rs[i]   = '0;
            rsrc[i] = SRC_NONE;
        end
        do_goto    = 1'b0;
        do_next    = 1'b0;
        do_req     = 1'b0;
        stop       = 1'b0;
        skip       = 1'b0;
        goto_cl    = '0;
        fsz        = '0;
        want       = '0;
        s_inc      = {1'b0, sic_reg} + 9'd1;
        e          = bis_reg[4:0];
        b          = in_data.data_byte;
        sector_end = (bis_reg == BW'(fat32rl_pkg::SECTOR_BYTES - 1));

        case (in_data.action)
            fat32rl_pkg::ACT_START:
            begin
                owner_next = 1'b0;
                ene_next   = 1'b1;
                do_goto    = 1'b1;
                goto_cl    = {4'd0, root_reg};
            end
            fat32rl_pkg::ACT_FAIL:
            begin
                if (phase_reg == PH_FAT)
                begin
                    do_goto = 1'b1;
                    goto_cl = fat32rl_pkg::FAT_MASK;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_IDLE;
                    rk[n[0]]   = fat32rl_pkg::K_ERR;
                    n          = n + 2'd1;
                end
            end
            fat32rl_pkg::ACT_BYTE:
            begin
                case (phase_reg)
                    PH_DIR:
                    begin
                        if (e == 5'd0)
                        begin
                            if (b == fat32rl_pkg::ENTRY_END)
                            begin
                                phase_next = PH_IDLE;
                                rk[n[0]]   = fat32rl_pkg::K_NOTFOUND;
                                n          = n + 2'd1;
                                stop       = 1'b1;
                            end
                            else
                            begin
                                efb_next = b;
                                ene_next = 1'b1;
                            end
                        end
                        if (!stop)
                        begin
                            if (e < 5'd8)
                            begin
                                want = name_reg[{e[2:0], 3'b000} +: 8];
                                if (b != want)
                                    ene_next = 1'b0;
                            end
                            else if (e < 5'd11)
                            begin
                                want = ext_reg[{e[1:0], 3'b000} +: 8];
                                if (b != want)
                                    ene_next = 1'b0;
                            end
                            else if (e == 5'd11)
                                attr_next = b;
                            else if (e == 5'd20)
                                fc_next[23:16] = b;
                            else if (e == 5'd21)
                                fc_next[31:24] = b;
                            else if (e == 5'd26)
                                fc_next[7:0] = b;
                            else if (e == 5'd27)
                                fc_next[15:8] = b;
                            else if (e >= 5'd28)
                                fs_next[{e[1:0], 3'b000} +: 8] = b;

                            if (e == 5'd31)
                            begin
                                skip = (efb_next == fat32rl_pkg::ENTRY_DELETED)
                                    || (attr_next == fat32rl_pkg::ATTR_LONG_NAME)
                                    || ((attr_next & fat32rl_pkg::ATTR_VOLUME) != 8'd0)
                                    || ((attr_next & fat32rl_pkg::ATTR_SUBDIR) != 8'd0)
                                    || !ene_next;
                                ene_next = 1'b1;
                                if (!skip)
                                begin
                                    stop    = 1'b1;
                                    fsz     = (fs_next > max_reg) ? max_reg : fs_next;
                                    fs_next = fsz;
                                    if (fsz == 32'd0 || fc_next >= fat32rl_pkg::EOC_MIN)
                                    begin
                                        phase_next = PH_IDLE;
                                        rk[n[0]]   = fat32rl_pkg::K_FOUND;
                                        rs[n[0]]   = fsz;
                                        n          = n + 2'd1;
                                    end
                                    else
                                    begin
                                        br_next    = fsz;
                                        owner_next = 1'b1;
                                        cc_next    = fc_next;
                                        sic_next   = '0;
                                        if (sector_end)
                                            do_req = 1'b1;
                                        else
                                            phase_next = PH_DRAIN;
                                    end
                                end
                            end
                            if (!stop && sector_end)
                                do_next = 1'b1;
                        end
                    end
                    PH_DRAIN:
                    begin
                        if (sector_end)
                            do_req = 1'b1;
                    end
                    PH_FILE:
                    begin
                        if (br_reg != 32'd0)
                        begin
                            rk[n[0]] = fat32rl_pkg::K_BYTE;
                            rb[n[0]] = b;
                            n        = n + 2'd1;
                            br_next  = br_reg - 32'd1;
                            if (br_next == 32'd0)
                            begin
                                phase_next = PH_IDLE;
                                rk[n[0]]   = fat32rl_pkg::K_FOUND;
                                rs[n[0]]   = fs_reg;
                                n          = n + 2'd1;
                            end
                        end
                        if (phase_next == PH_FILE && sector_end)
                            do_next = 1'b1;
                    end
                    PH_FAT:
                    begin
                        if (bis_reg[BW-1:2] == cc_reg[6:0])
                            fatw_next[{bis_reg[1:0], 3'b000} +: 8] =
                                fatw_reg[{bis_reg[1:0], 3'b000} +: 8] | b;
                        if (sector_end)
                        begin
                            do_goto = 1'b1;
                            goto_cl = fatw_next & fat32rl_pkg::FAT_MASK;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // follow the chain
        if (do_goto)
        begin
            if (goto_cl >= fat32rl_pkg::EOC_MIN)
            begin
                phase_next = PH_IDLE;
                rk[n[0]]   = owner_next ? fat32rl_pkg::K_FOUND : fat32rl_pkg::K_NOTFOUND;
                rs[n[0]]   = owner_next ? fs_next : 32'd0;
                n          = n + 2'd1;
            end
            else
            begin
                cc_next  = goto_cl;
                sic_next = '0;
                do_req   = 1'b1;
            end
        end

        // sector used up: next sector of the cluster, else FAT lookup
        if (do_next)
        begin
            if (s_inc < {1'b0, spc_reg})
            begin
                sic_next = s_inc[7:0];
                do_req   = 1'b1;
            end
            else
            begin
                bis_next   = '0;
                fatw_next  = '0;
                phase_next = PH_FAT;
                rk[n[0]]   = fat32rl_pkg::K_REQ;
                rsrc[n[0]] = SRC_FAT;
                n          = n + 2'd1;
            end
        end

        if (do_req)
        begin
            bis_next   = '0;
            phase_next = owner_next ? PH_FILE : PH_DIR;
            rk[n[0]]   = fat32rl_pkg::K_REQ;
            rsrc[n[0]] = SRC_DATA;
            n          = n + 2'd1;
        end

        if (in_data.action == fat32rl_pkg::ACT_BYTE && phase_reg != PH_IDLE && !sector_end)
        begin
            if (phase_next != PH_IDLE && n == 2'd0)
                bis_next = bis_reg + 1'b1;
            else if (n != 2'd0 && (phase_next == PH_FILE || phase_next == PH_DIR)
                     && rk[0] == fat32rl_pkg::K_BYTE)
                bis_next = bis_reg + 1'b1;
        end
    end

    // one multiplier: sector address of the cluster being read
    assign data_lba = data_start_reg + 32'((cc_next - 32'd2) * {24'd0, spc_reg})
                      + {24'd0, sic_next};
    assign fat_lba  = fat_start_reg + {9'd0, cc_next[29:7]};

    always_comb
    begin
        push.count         = in_fire ? n : 2'd0;
        push.first.kind          = rk[0];
        push.first.file_byte     = rb[0];
        push.first.reported_size = rs[0];
        push.first.last          = (n == 2'd1);
        push.first.sector_lba    = (rsrc[0] == SRC_DATA) ? data_lba :
                                   (rsrc[0] == SRC_FAT)  ? fat_lba  : 32'd0;
        push.second.kind          = rk[1];
        push.second.file_byte     = rb[1];
        push.second.reported_size = rs[1];
        push.second.last          = 1'b1;
        push.second.sector_lba    = (rsrc[1] == SRC_DATA) ? data_lba :
                                    (rsrc[1] == SRC_FAT)  ? fat_lba  : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            owner_reg <= 1'b0;
            cc_reg    <= '0;
            sic_reg   <= '0;
            bis_reg   <= '0;
            efb_reg   <= '0;
            attr_reg  <= '0;
            ene_reg   <= 1'b1;
            fc_reg    <= '0;
            fs_reg    <= '0;
            br_reg    <= '0;
            fatw_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            owner_reg <= owner_next;
            cc_reg    <= cc_next;
            sic_reg   <= sic_next;
            bis_reg   <= bis_next;
            efb_reg   <= efb_next;
            attr_reg  <= attr_next;
            ene_reg   <= ene_next;
            fc_reg    <= fc_next;
            fs_reg    <= fs_next;
            br_reg    <= br_next;
            fatw_reg  <= fatw_next;
        end
    end

endmodule

>>> rtl/core/fat32rl_queue.sv
// Back part: result queue taking up to two records per cycle, one out per transfer.
// Depends on fat32rl_pkg.
module fat32rl_queue
#(
    parameter int DEPTH = fat32rl_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fat32rl_pkg::push_t   push,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fat32rl_pkg::out_t    out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    fat32rl_pkg::out_t mem_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next, tail_1;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // two free slots needed: one transfer may bring two results
    assign space     = (count_reg <= CW'(DEPTH - 2));
    assign tail_1    = wrap_inc(tail_reg);

    always_comb
    begin
        head_next  = pop ? wrap_inc(head_reg) : head_reg;
        tail_next  = (push.count == 2'd2) ? wrap_inc(tail_1) :
                     (push.count == 2'd1) ? tail_1 : tail_reg;
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[tail_1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/fat32_root_file_loader.sv
// FAT32 root file loader. One input transfer (start, sector byte or read failure) is taken
// per clock; the state machine settles each byte in the cycle it arrives, so sector data
// streams at one byte a cycle. Results go through a QUEUE_DEPTH-entry queue and input is
// taken while at least two entries are free, since the final file byte also brings the
// done result; with the output side always ready the rate is one transfer per cycle.
// Depends on fat32rl_pkg, fat32rl_engine and fat32rl_queue.
module fat32_root_file_loader
#(
    parameter int QUEUE_DEPTH = fat32rl_pkg::QUEUE_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  fat32rl_pkg::in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output fat32rl_pkg::out_t                    out_data,
    input  logic                                 cfg_we,
    input  logic [fat32rl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fat32rl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fat32rl_pkg::push_t push;
    logic               space;

    assign in_ready = space;

    fat32rl_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_valid && space),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    fat32rl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/fat32rl_checker.sv
// Port-level checks on the loader's result stream, bound to the top level.
// Depends on fat32rl_pkg.
module fat32rl_sva
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input fat32rl_pkg::out_t out_data
);

    // a waiting result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // terminal results always close their step
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == fat32rl_pkg::K_FOUND
                   || out_data.kind == fat32rl_pkg::K_NOTFOUND
                   || out_data.kind == fat32rl_pkg::K_ERR) |-> out_data.last)
        else $error("terminal result without last");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == fat32rl_pkg::K_BYTE
        |-> out_data.sector_lba == 32'd0 && out_data.reported_size == 32'd0)
        else $error("file byte carries stray fields");

    a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == fat32rl_pkg::K_REQ
        |-> out_data.file_byte == 8'd0 && out_data.reported_size == 32'd0 && out_data.last)
        else $error("read request malformed");

endmodule

bind fat32_root_file_loader fat32rl_sva u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> dv/fat32rl_checker.sv
// Result checker for the FAT32 root file loader: watches the input, result and register
// ports, predicts every result from the transfers it sees and compares in order.
// Depends on fat32rl_pkg.
module fat32rl_checker
    import fat32rl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {PH_IDLE, PH_DIR, PH_DRAIN, PH_FILE, PH_FAT} phase_t;

    localparam int MAX_REPORTS = 60;

    // register copies
    logic [63:0] tgt_name;
    logic [23:0] tgt_ext;
    logic [31:0] root_cl, fat_base, data_base, spc, size_cap;

    // walker state
    phase_t      phase;
    logic        owner_file;
    logic [31:0] cur_cl, sect;
    logic [8:0]  bis;
    logic [7:0]  ent_first, ent_attr;
    logic        name_eq;
    logic [31:0] found_cl, found_size, remaining, fat_word;

    out_t        expected_q[$];
    int          n_new;
    logic [2:0]  first_kind;
    int          fail_cnt;

    task add_result(input logic [2:0] kind, input logic [31:0] lba, input logic [7:0] b,
                    input logic [31:0] size);
        out_t r;
        r = '0;
        r.kind = kind;
        r.sector_lba = lba;
        r.file_byte = b;
        r.reported_size = size;
        if (n_new == 0)
            first_kind = kind;
        n_new++;
        expected_q.push_back(r);
    endtask

    function automatic logic [31:0] cluster_lba(input logic [31:0] cl, input logic [31:0] s);
        return data_base + (cl - 32'd2) * spc + s;
    endfunction

    task request_sector();
        bis = '0;
        phase = owner_file ? PH_FILE : PH_DIR;
        add_result(K_REQ, cluster_lba(cur_cl, sect), 8'h00, 32'h0);
    endtask

    task close_out(input logic [2:0] kind, input logic [31:0] size);
        phase = PH_IDLE;
        add_result(kind, 32'h0, 8'h00, size);
    endtask

    task next_sector();
        logic [31:0] offs;
        offs = cur_cl << 2;
        if (sect + 32'd1 < spc) begin
            sect = sect + 32'd1;
            request_sector();
        end
        else begin
            bis = '0;
            fat_word = '0;
            phase = PH_FAT;
            add_result(K_REQ, fat_base + (offs >> 9), 8'h00, 32'h0);
        end
    endtask

    task follow(input logic [31:0] cl);
        if (cl >= EOC_MIN) begin
            if (owner_file)
                close_out(K_FOUND, found_size);
            else
                close_out(K_NOTFOUND, 32'h0);
        end
        else begin
            cur_cl = cl;
            sect = '0;
            request_sector();
        end
    endtask

    task dir_byte(input logic [7:0] b, input logic se);
        int   e;
        logic [7:0] want;
        logic skip;
        e = int'(bis[4:0]);
        if (e == 0) begin
            if (b == ENTRY_END) begin
                close_out(K_NOTFOUND, 32'h0);
                return;
            end
            ent_first = b;
            name_eq = 1'b1;
        end
        if (e < 11) begin
            if (e < 8)
                want = tgt_name[8*e +: 8];
            else
                want = tgt_ext[8*(e-8) +: 8];
            if (b != want)
                name_eq = 1'b0;
        end
        else if (e == 11)
            ent_attr = b;
        else if (e == 20)
            found_cl[23:16] = b;
        else if (e == 21)
            found_cl[31:24] = b;
        else if (e == 26)
            found_cl[7:0] = b;
        else if (e == 27)
            found_cl[15:8] = b;
        else if (e >= 28)
            found_size[8*(e-28) +: 8] = b;
        if (e == 31) begin
            skip = ent_first == ENTRY_DELETED || ent_attr == ATTR_LONG_NAME
                || (ent_attr & ATTR_VOLUME) != 0 || (ent_attr & ATTR_SUBDIR) != 0 || !name_eq;
            name_eq = 1'b1;
            if (!skip) begin
                if (found_size > size_cap)
                    found_size = size_cap;
                if (found_size == 0 || found_cl >= EOC_MIN) begin
                    close_out(K_FOUND, found_size);
                    return;
                end
                remaining = found_size;
                owner_file = 1'b1;
                cur_cl = found_cl;
                sect = '0;
                if (se)
                    request_sector();
                else
                    phase = PH_DRAIN;
                return;
            end
        end
        if (se)
            next_sector();
    endtask

    task step(input logic [1:0] act, input logic [7:0] b);
        logic        se;
        logic [8:0]  offs;
        n_new = 0;
        if (act == ACT_START) begin
            owner_file = 1'b0;
            name_eq = 1'b1;
            follow(root_cl);
        end
        else if (act == ACT_FAIL) begin
            if (phase == PH_FAT)
                follow(FAT_MASK);
            else if (phase != PH_IDLE)
                close_out(K_ERR, 32'h0);
        end
        else if (act == ACT_BYTE && phase != PH_IDLE) begin
            se = bis >= 9'(SECTOR_BYTES - 1);
            case (phase)
                PH_DIR:   dir_byte(b, se);
                PH_DRAIN: if (se) request_sector();
                PH_FILE:
                begin
                    if (remaining > 0) begin
                        add_result(K_BYTE, 32'h0, b, 32'h0);
                        remaining = remaining - 32'd1;
                        if (remaining == 0)
                            close_out(K_FOUND, found_size);
                    end
                    if (phase == PH_FILE && se)
                        next_sector();
                end
                default:
                begin
                    offs = cur_cl[6:0] << 2;
                    if ({bis[8:2], 2'b00} == offs)
                        fat_word[8*bis[1:0] +: 8] = fat_word[8*bis[1:0] +: 8] | b;
                    if (se)
                        follow(fat_word & FAT_MASK);
                end
            endcase
            // the byte counter moves only while the sector is still being consumed
            if (phase != PH_IDLE && !se && n_new == 0)
                bis = bis + 9'd1;
            else if (!se && n_new > 0 && (phase == PH_FILE || phase == PH_DIR)
                     && first_kind == K_BYTE)
                bis = bis + 9'd1;
        end
        if (n_new > 0)
            expected_q[$].last = 1'b1;
    endtask

    task report(input string field, input logic [31:0] want, input logic [31:0] got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        out_t want;
        if (!rst_n) begin
            tgt_name = '0;
            tgt_ext = '0;
            root_cl = 32'd2;
            fat_base = '0;
            data_base = '0;
            spc = 32'd1;
            size_cap = '0;
            phase = PH_IDLE;
            owner_file = 1'b0;
            cur_cl = '0;
            sect = '0;
            bis = '0;
            ent_first = '0;
            ent_attr = '0;
            name_eq = 1'b1;
            found_cl = '0;
            found_size = '0;
            remaining = '0;
            fat_word = '0;
            expected_q.delete();
            fail_cnt = 0;
            failures <= 0;
            pending <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result kind", 32'h0, 32'(out_data.kind));
                end
                else begin
                    want = expected_q.pop_front();
                    if (out_data.kind !== want.kind)
                        report("kind", 32'(want.kind), 32'(out_data.kind));
                    if (out_data.sector_lba !== want.sector_lba)
                        report("sector_lba", want.sector_lba, out_data.sector_lba);
                    if (out_data.file_byte !== want.file_byte)
                        report("file_byte", 32'(want.file_byte), 32'(out_data.file_byte));
                    if (out_data.reported_size !== want.reported_size)
                        report("reported_size", want.reported_size, out_data.reported_size);
                    if (out_data.last !== want.last)
                        report("last", 32'(want.last), 32'(out_data.last));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_NAME:  tgt_name = cfg_data;
                    REG_TARGET_EXT:   tgt_ext = cfg_data[23:0];
                    REG_ROOT_CLUSTER: root_cl = {4'h0, cfg_data[27:0]};
                    REG_FAT_START:    fat_base = cfg_data[31:0];
                    REG_DATA_START:   data_base = cfg_data[31:0];
                    REG_SPC:          spc = {24'h0, cfg_data[7:0]};
                    REG_MAX_SIZE:     size_cap = cfg_data[31:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                step(in_data.action, in_data.data_byte);
            failures <= fail_cnt;
            pending <= expected_q.size();
        end
    end

endmodule

>>> dv/tb.sv
// Testbench top for the FAT32 root file loader: builds a small disk image per session,
// answers the block's sector reads with bytes from it, else random ones, and gives the verdict.
// Depends on fat32rl_pkg, fat32_root_file_loader and fat32rl_checker.
module tb;
    import fat32rl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int N_ITEMS = 1650;

    localparam int MODE_RANDOM     = 0;
    localparam int MODE_ROOT_END   = 1;
    localparam int MODE_EMPTY_FILE = 2;
    localparam int MODE_CLAMP      = 3;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    failures;
    int                    pending;

    logic [63:0] reg_val [7];
    logic [7:0]  disk [logic [40:0]];
    logic [31:0] lba_q[$];
    bit          session_over;
    bit          steady;
    int          items;

    fat32_root_file_loader dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fat32rl_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 18);

    // read requests to serve, and the end of a search or load
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (out_data.kind == K_REQ)
                lba_q.push_back(out_data.sector_lba);
            else if (out_data.kind != K_BYTE)
                session_over = 1'b1;
        end
    end

    task automatic send(input logic [1:0] act, input logic [7:0] b);
        if (!steady && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{action: act, data_byte: b};
        do @(posedge clk); while (!in_ready);
        items++;
        steady = items >= 700 && items < 1100;
    endtask

    // hold input until every predicted result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_regs();
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= reg_val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] cl_lba(input logic [31:0] cl);
        return reg_val[REG_DATA_START][31:0] + (cl - 32'd2) * reg_val[REG_SPC][31:0];
    endfunction

    task automatic put_entry(input logic [31:0] lba, input int idx, input logic [7:0] first,
                             input logic [63:0] name, input logic [7:0] attr,
                             input logic [31:0] cl, input logic [31:0] size);
        logic [7:0] ent [32];
        for (int k = 0; k < 32; k++)
            ent[k] = 8'($urandom);
        for (int k = 0; k < 8; k++)
            ent[k] = name[8*k +: 8];
        for (int k = 0; k < 3; k++)
            ent[8+k] = reg_val[REG_TARGET_EXT][8*k +: 8];
        ent[0] = first;
        ent[11] = attr;
        ent[20] = cl[23:16];
        ent[21] = cl[31:24];
        ent[26] = cl[7:0];
        ent[27] = cl[15:8];
        for (int k = 0; k < 4; k++)
            ent[28+k] = size[8*k +: 8];
        for (int k = 0; k < 32; k++)
            disk[{lba, 9'(32*idx + k)}] = ent[k];
    endtask

    task automatic put_fat(input logic [31:0] cl, input logic [31:0] nxt);
        logic [31:0] offs, lba, word;
        offs = cl << 2;
        lba = reg_val[REG_FAT_START][31:0] + (offs >> 9);
        word = {4'($urandom), nxt[27:0]};
        for (int k = 0; k < 4; k++)
            disk[{lba, {offs[8:2], 2'(k)}}] = word[8*k +: 8];
    endtask

    function automatic logic [31:0] chain_end();
        return EOC_MIN + 32'($urandom_range(0, 7));
    endfunction

    task automatic serve(input logic [31:0] lba);
        int fail_at, restart_at;
        logic [7:0] b;
        fail_at = $urandom_range(99) < 4 ? $urandom_range(0, 511) : 600;
        restart_at = $urandom_range(99) < 2 ? $urandom_range(0, 511) : 600;
        for (int i = 0; i < SECTOR_BYTES; i++) begin
            if (session_over || items >= N_ITEMS)
                break;
            if (i == fail_at) begin
                send(ACT_FAIL, 8'($urandom));
                break;
            end
            if (i == restart_at) begin
                send(ACT_START, 8'($urandom));
                break;
            end
            if ($urandom_range(99) == 0)
                send(ACT_UNUSED, 8'($urandom));
            if (disk.exists({lba, 9'(i)}))
                b = disk[{lba, 9'(i)}];
            else if (i == 0 && $urandom_range(1) == 0)
                b = ENTRY_END;
            else
                b = 8'($urandom);
            send(ACT_BYTE, b);
        end
    endtask

    task automatic run_session(input int mode);
        logic [63:0] name, bad;
        logic [31:0] root, fcl, size, dir_lba, c, nxt;
        int n_skip, ending, pick;
        settle();
        name = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            name = '1;
        reg_val[REG_TARGET_NAME] = name;
        reg_val[REG_TARGET_EXT] = 64'($urandom_range(0, 24'hFFFFFF));
        pick = $urandom_range(9);
        root = pick == 0 ? 32'h0 : pick == 1 ? FAT_MASK : 32'($urandom_range(2, 40));
        if (mode == MODE_ROOT_END)
            root = chain_end();
        reg_val[REG_ROOT_CLUSTER] = 64'(root);
        pick = $urandom_range(9);
        reg_val[REG_FAT_START] = pick == 0 ? 64'h0 : pick == 1 ? 64'hFFFF_FFFF : 64'($urandom);
        pick = $urandom_range(9);
        reg_val[REG_DATA_START] = pick == 0 ? 64'h0 : pick == 1 ? 64'hFFFF_FFFF : 64'($urandom);
        pick = $urandom_range(9);
        reg_val[REG_SPC] = pick == 0 ? 64'd0 : pick == 1 ? 64'd255
                         : pick < 6 ? 64'd1 : 64'($urandom_range(2, 4));
        pick = $urandom_range(9);
        size = pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF
             : pick < 7 ? 32'($urandom_range(1, 40)) : 32'($urandom_range(100, 1200));
        pick = $urandom_range(9);
        reg_val[REG_MAX_SIZE] = pick == 0 ? 64'h0 : pick == 1 ? 64'hFFFF_FFFF
                              : 64'($urandom_range(0, 1500));
        if (mode == MODE_EMPTY_FILE)
            size = 32'h0;
        if (mode == MODE_CLAMP)
            reg_val[REG_MAX_SIZE] = 64'($urandom_range(1, 20));
        if (mode == MODE_CLAMP || size == 32'hFFFF_FFFF) begin
            size = 32'hFFFF_FFFF;
            if (reg_val[REG_MAX_SIZE] == 64'hFFFF_FFFF)
                reg_val[REG_MAX_SIZE] = 64'($urandom_range(1, 1500));
        end
        fcl = $urandom_range(9) == 0 ? chain_end() : 32'($urandom_range(41, 80));
        write_regs();

        disk.delete();
        dir_lba = cl_lba(root);
        n_skip = $urandom_range(0, 5);
        ending = $urandom_range(0, 3);
        if (mode != MODE_RANDOM) begin
            n_skip = mode == MODE_EMPTY_FILE ? 0 : n_skip;
            ending = 2;
        end
        for (int k = 0; k < n_skip; k++) begin
            bad = name;
            bad[$urandom_range(0, 63)] ^= 1'b1;
            case ($urandom_range(4))
                0: put_entry(dir_lba, k, ENTRY_DELETED, name, 8'h20, fcl, size);
                1: put_entry(dir_lba, k, name[7:0], name, ATTR_LONG_NAME, fcl, size);
                2: put_entry(dir_lba, k, name[7:0], name, ATTR_VOLUME | 8'h20, fcl, size);
                3: put_entry(dir_lba, k, name[7:0], name, ATTR_SUBDIR, fcl, size);
                default: put_entry(dir_lba, k, bad[7:0], bad, 8'h20, fcl, size);
            endcase
        end
        if (ending == 0)
            disk[{dir_lba, 9'(32*n_skip)}] = ENTRY_END;
        else if (ending == 1) begin
            for (int k = n_skip; k < 16; k++) begin
                bad = {$urandom, $urandom};
                put_entry(dir_lba, k, bad[7:0] | 8'h01, bad, 8'h00, fcl, size);
            end
        end
        else
            put_entry(dir_lba, n_skip, name[7:0], name, 8'($urandom) & ~8'h18, fcl, size);
        put_fat(root, $urandom_range(1) == 0 ? chain_end() : 32'($urandom_range(81, 100)));
        c = fcl;
        for (int j = 0; j < 3; j++) begin
            nxt = (j == 2 || $urandom_range(1) == 0) ? chain_end()
                : 32'($urandom_range(101, 140));
            put_fat(c, nxt);
            if (nxt >= EOC_MIN)
                break;
            c = nxt;
        end

        session_over = 1'b0;
        lba_q.delete();
        send(ACT_START, 8'($urandom));
        forever begin
            in_valid <= 1'b0;
            do @(posedge clk);
            while (lba_q.size() == 0 && !session_over && items < N_ITEMS);
            if (session_over || items >= N_ITEMS)
                break;
            serve(lba_q.pop_front());
        end
    endtask

    initial begin
        reg_val = '{default: '0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // traffic while idle is dropped
        send(ACT_BYTE, 8'h00);
        send(ACT_FAIL, 8'hFF);
        send(ACT_UNUSED, 8'hA5);
        run_session(MODE_ROOT_END);
        run_session(MODE_EMPTY_FILE);
        run_session(MODE_CLAMP);
        while (items < N_ITEMS)
            run_session(MODE_RANDOM);
        settle();
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (failures == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/fat32rl_pkg.sv
rtl/core/fat32rl_engine.sv
rtl/core/fat32rl_queue.sv
rtl/core/fat32_root_file_loader.sv
rtl/core/fat32rl_checker.sv
dv/fat32rl_checker.sv
dv/tb.sv
